// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// Property checked in the cycle after its trigger.
`define CHK_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

// ----- design/l1vl2_pkg.sv -----
// Shared types and constants of the L1/victim/L2 tag model.
`default_nettype none
package l1vl2_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_L1_INDEX_BITS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_L1_WAYS        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VICTIM_ENTRIES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_ENABLE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_INDEX_BITS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS        = 3'd5;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_L1_RD,
		ST_L1_UPD,
		ST_L2W_RD,
		ST_L2W_UPD,
		ST_L2R_RD,
		ST_L2R_UPD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic clr;
		logic l1_rd;
		logic l1_upd;
		logic l2w_rd;
		logic l2w_upd;
		logic l2r_rd;
		logic l2r_upd;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic l1_need_w;
		logic l1_need_r;
		logic l2r_pend;
	} sts_t;

endpackage
`default_nettype wire

// ----- design/l1vl2_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module l1vl2_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- design/l1vl2_ctrl.sv -----
// Sequencer: steps one item through L1, victim and L2 phases.
`default_nettype none
module l1vl2_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  l1vl2_pkg::sts_t   sts,
	output l1vl2_pkg::cmd_t   cmd
);
	import l1vl2_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_L1_RD;
				end
			end
			ST_L1_RD: begin
				cmd.l1_rd = 1'b1;
				state_d   = ST_L1_UPD;
			end
			ST_L1_UPD: begin
				cmd.l1_upd = 1'b1;
				if (sts.l1_need_w) begin
					state_d = ST_L2W_RD;
				end else if (sts.l1_need_r) begin
					state_d = ST_L2R_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_L2W_RD: begin
				cmd.l2w_rd = 1'b1;
				state_d    = ST_L2W_UPD;
			end
			ST_L2W_UPD: begin
				cmd.l2w_upd = 1'b1;
				state_d     = sts.l2r_pend ? ST_L2R_RD : ST_DONE;
			end
			ST_L2R_RD: begin
				cmd.l2r_rd = 1'b1;
				state_d    = ST_L2R_UPD;
			end
			ST_L2R_UPD: begin
				cmd.l2r_upd = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- design/l1vl2_dp.sv -----
// Datapath: config registers, L1 and L2 tag RAMs, victim entries, result registers.
`default_nettype none
module l1vl2_dp #(
	parameter int L1_SET_BITS  = 8,
	parameter int L1_WAYS      = 4,
	parameter int VICTIM_DEPTH = 8,
	parameter int L2_SET_BITS  = 10,
	parameter int L2_WAYS      = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [l1vl2_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [l1vl2_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  l1vl2_pkg::cmd_t                     cmd,
	output l1vl2_pkg::sts_t                     sts,
	input  logic                                kind,
	input  logic [31:0]                         block_addr,
	output logic                                l1_hit,
	output logic                                swap_request,
	output logic                                victim_hit,
	output logic                                l1_writeback,
	output logic                                l2_read_issued,
	output logic                                l2_write_issued,
	output logic                                l2_read_miss,
	output logic                                l2_write_miss,
	output logic [1:0]                          l2_writebacks
);
	import l1vl2_pkg::*;

	localparam int L1_SW    = (L1_SET_BITS > 0) ? L1_SET_BITS : 1;
	localparam int L1_DEPTH = 1 << L1_SET_BITS;
	localparam int L1_RW    = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
	localparam int L1_EW    = 34 + L1_RW;
	localparam int L1_ROW   = L1_WAYS * L1_EW;
	localparam int VRW      = (VICTIM_DEPTH > 1) ? $clog2(VICTIM_DEPTH) : 1;
	localparam int L2_SW    = (L2_SET_BITS > 0) ? L2_SET_BITS : 1;
	localparam int L2_DEPTH = 1 << L2_SET_BITS;
	localparam int L2_RW    = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
	localparam int L2_EW    = 34 + L2_RW;
	localparam int L2_ROW   = L2_WAYS * L2_EW;

	// configuration
	logic [3:0] l1_ib_q, ve_cfg_q, l2_ib_q, l2_ways_q;
	logic [2:0] l1_ways_q;
	logic       l2_en_q;
	logic [3:0] b1, b2;
	logic [4:0] n1, ve, n2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_ib_q   <= 4'd8;
			l1_ways_q <= 3'd4;
			ve_cfg_q  <= 4'd8;
			l2_en_q   <= 1'b1;
			l2_ib_q   <= 4'd10;
			l2_ways_q <= 4'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_L1_INDEX_BITS:  l1_ib_q   <= cfg_data;
				CFG_L1_WAYS:        l1_ways_q <= cfg_data[2:0];
				CFG_VICTIM_ENTRIES: ve_cfg_q  <= cfg_data;
				CFG_L2_ENABLE:      l2_en_q   <= cfg_data[0];
				CFG_L2_INDEX_BITS:  l2_ib_q   <= cfg_data;
				CFG_L2_WAYS:        l2_ways_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign b1 = (l1_ib_q > 4'(L1_SET_BITS)) ? 4'(L1_SET_BITS) : l1_ib_q;
	assign b2 = (l2_ib_q > 4'(L2_SET_BITS)) ? 4'(L2_SET_BITS) : l2_ib_q;
	assign n1 = (l1_ways_q == 3'd0) ? 5'd1 :
		((5'(l1_ways_q) > 5'(L1_WAYS)) ? 5'(L1_WAYS) : 5'(l1_ways_q));
	assign ve = (5'(ve_cfg_q) > 5'(VICTIM_DEPTH)) ? 5'(VICTIM_DEPTH) : 5'(ve_cfg_q);
	assign n2 = (l2_ways_q == 4'd0) ? 5'd1 :
		((5'(l2_ways_q) > 5'(L2_WAYS)) ? 5'(L2_WAYS) : 5'(l2_ways_q));

	// item
	logic        kind_q;
	logic [31:0] addr_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= kind;
			addr_q <= block_addr;
		end
	end

	// L1 tag RAM, one row per set; rows never written read as reset
	logic [L1_SW-1:0]    l1_set;
	logic [L1_ROW-1:0]   l1_rrow, l1_wrow;
	logic [L1_DEPTH-1:0] l1_init_q;
	logic                l1_row_init_q;

	assign l1_set = addr_q[L1_SW-1:0] & ~({L1_SW{1'b1}} << b1);

	l1vl2_ram #(.WIDTH(L1_ROW), .DEPTH(L1_DEPTH)) u_l1_ram (
		.clk   (clk),
		.we    (cmd.l1_upd),
		.waddr (l1_set),
		.wdata (l1_wrow),
		.re    (cmd.l1_rd),
		.raddr (l1_set),
		.rdata (l1_rrow)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_init_q <= '0;
		end else if (cmd.l1_upd) begin
			l1_init_q[l1_set] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.l1_rd) begin
			l1_row_init_q <= l1_init_q[l1_set];
		end
	end

	logic [31:0]      l1a [L1_WAYS];
	logic [L1_RW-1:0] l1r [L1_WAYS];
	logic [L1_RW-1:0] l1rn [L1_WAYS];
	logic [31:0]      wa [L1_WAYS];
	logic [L1_WAYS-1:0] l1v, l1d, use1, hitv, wv, wd;
	logic [L1_RW-1:0] hw, lw, lr, tw, tr;
	logic             hit;

	always_comb begin
		for (int w = 0; w < L1_WAYS; w++) begin
			l1a[w]  = l1_rrow[w*L1_EW +: 32];
			l1v[w]  = l1_row_init_q & l1_rrow[w*L1_EW+32];
			l1d[w]  = l1_row_init_q & l1_rrow[w*L1_EW+33];
			l1r[w]  = l1_row_init_q ? l1_rrow[w*L1_EW+34 +: L1_RW] : L1_RW'(w);
			use1[w] = 5'(w) < n1;
			hitv[w] = use1[w] & l1v[w] & ((l1a[w] >> b1) == (addr_q >> b1));
		end
	end

	always_comb begin
		hw = '0;
		for (int w = L1_WAYS - 1; w >= 0; w--) begin
			if (hitv[w]) begin
				hw = L1_RW'(w);
			end
		end
		lw = '0;
		lr = l1r[0];
		for (int w = 1; w < L1_WAYS; w++) begin
			if (use1[w] && (l1r[w] > lr)) begin
				lw = L1_RW'(w);
				lr = l1r[w];
			end
		end
	end

	assign hit = |hitv;
	assign tw  = hit ? hw : lw;
	assign tr  = l1r[tw];

	always_comb begin
		for (int w = 0; w < L1_WAYS; w++) begin
			if (L1_RW'(w) == tw) begin
				l1rn[w] = '0;
			end else if (use1[w] && (l1r[w] < tr)) begin
				l1rn[w] = L1_RW'(l1r[w] + 1'b1);
			end else begin
				l1rn[w] = l1r[w];
			end
		end
	end

	// victim entries
	logic [31:0]           vaddr_q [VICTIM_DEPTH];
	logic [VRW-1:0]        vrank_q [VICTIM_DEPTH];
	logic [VRW-1:0]        vrn [VICTIM_DEPTH];
	logic [VICTIM_DEPTH-1:0] vvalid_q, vdirty_q, vuse, vmv;
	logic [VRW-1:0]        kh, kl, klr, kt, vtr;
	logic                  vfound;

	always_comb begin
		for (int k = 0; k < VICTIM_DEPTH; k++) begin
			vuse[k] = 5'(k) < ve;
			vmv[k]  = vuse[k] & vvalid_q[k] & (vaddr_q[k] == addr_q);
		end
		kh = '0;
		for (int k = VICTIM_DEPTH - 1; k >= 0; k--) begin
			if (vmv[k]) begin
				kh = VRW'(k);
			end
		end
		kl  = '0;
		klr = vrank_q[0];
		for (int k = 1; k < VICTIM_DEPTH; k++) begin
			if (vuse[k] && (vrank_q[k] > klr)) begin
				kl  = VRW'(k);
				klr = vrank_q[k];
			end
		end
	end

	assign vfound = |vmv;
	assign kt     = vfound ? kh : kl;
	assign vtr    = vrank_q[kt];

	always_comb begin
		for (int k = 0; k < VICTIM_DEPTH; k++) begin
			if (VRW'(k) == kt) begin
				vrn[k] = '0;
			end else if (vuse[k] && (vrank_q[k] < vtr)) begin
				vrn[k] = VRW'(vrank_q[k] + 1'b1);
			end else begin
				vrn[k] = vrank_q[k];
			end
		end
	end

	// access outcome
	logic swp, vhit, wb, need_w, need_r;

	assign swp    = !hit && (ve != 5'd0) && l1v[lw];
	assign vhit   = swp && vfound;
	assign wb     = !hit && (swp ? (!vfound && vvalid_q[kl] && vdirty_q[kl])
		: (l1v[lw] && l1d[lw]));
	assign need_w = wb && l2_en_q;
	assign need_r = !hit && !vhit && l2_en_q;

	always_comb begin
		for (int w = 0; w < L1_WAYS; w++) begin
			wa[w] = l1a[w];
		end
		wv = l1v;
		wd = l1d;
		if (hit) begin
			if (kind_q) begin
				wd[hw] = 1'b1;
				wa[hw] = addr_q;
			end
		end else if (vhit) begin
			wa[lw] = vaddr_q[kh];
			wd[lw] = kind_q | vdirty_q[kh];
			wv[lw] = 1'b1;
		end else begin
			wa[lw] = addr_q;
			wv[lw] = 1'b1;
			wd[lw] = kind_q;
		end
		for (int w = 0; w < L1_WAYS; w++) begin
			l1_wrow[w*L1_EW +: L1_EW] = {l1rn[w], wd[w], wv[w], wa[w]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vvalid_q <= '0;
			vdirty_q <= '0;
			for (int k = 0; k < VICTIM_DEPTH; k++) begin
				vrank_q[k] <= VRW'(k);
			end
		end else if (cmd.l1_upd && swp) begin
			vvalid_q[kt] <= 1'b1;
			vdirty_q[kt] <= l1d[lw];
			vrank_q      <= vrn;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.l1_upd && swp) begin
			vaddr_q[kt] <= l1a[lw];
		end
	end

	// L2 tag RAM
	logic              op_wr, clear_last;
	logic [31:0]       op_addr, tag2, l2w_addr_q;
	logic [L2_SW-1:0]  l2_set, clr_cnt_q;
	logic [L2_ROW-1:0] l2_rrow, l2_wrow, l2_clr_row;
	logic [31:0]       ta [L2_WAYS];
	logic [31:0]       ta_n [L2_WAYS];
	logic [L2_RW-1:0]  t2r [L2_WAYS];
	logic [L2_RW-1:0]  t2rn [L2_WAYS];
	logic [L2_WAYS-1:0] tv, td, use2, hit2v, tv_n, td_n;
	logic [L2_RW-1:0]  hw2, lw2, lr2, t2, tr2;
	logic              hit2, ev_dirty;

	assign op_wr   = cmd.l2w_rd | cmd.l2w_upd;
	assign op_addr = op_wr ? l2w_addr_q : addr_q;
	assign l2_set  = op_addr[L2_SW-1:0] & ~({L2_SW{1'b1}} << b2);
	assign tag2    = op_addr >> b2;

	l1vl2_ram #(.WIDTH(L2_ROW), .DEPTH(L2_DEPTH)) u_l2_ram (
		.clk   (clk),
		.we    (cmd.l2w_upd | cmd.l2r_upd | cmd.clr),
		.waddr (cmd.clr ? clr_cnt_q : l2_set),
		.wdata (cmd.clr ? l2_clr_row : l2_wrow),
		.re    (cmd.l2w_rd | cmd.l2r_rd),
		.raddr (l2_set),
		.rdata (l2_rrow)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign clear_last = clr_cnt_q == L2_SW'(L2_DEPTH - 1);

	always_comb begin
		for (int w = 0; w < L2_WAYS; w++) begin
			l2_clr_row[w*L2_EW +: L2_EW] = {L2_RW'(w), 1'b0, 1'b0, 32'd0};
			ta[w]    = l2_rrow[w*L2_EW +: 32];
			tv[w]    = l2_rrow[w*L2_EW+32];
			td[w]    = l2_rrow[w*L2_EW+33];
			t2r[w]   = l2_rrow[w*L2_EW+34 +: L2_RW];
			use2[w]  = 5'(w) < n2;
			hit2v[w] = use2[w] & tv[w] & (ta[w] == tag2);
		end
	end

	always_comb begin
		hw2 = '0;
		for (int w = L2_WAYS - 1; w >= 0; w--) begin
			if (hit2v[w]) begin
				hw2 = L2_RW'(w);
			end
		end
		lw2 = '0;
		lr2 = t2r[0];
		for (int w = 1; w < L2_WAYS; w++) begin
			if (use2[w] && (t2r[w] > lr2)) begin
				lw2 = L2_RW'(w);
				lr2 = t2r[w];
			end
		end
	end

	assign hit2     = |hit2v;
	assign t2       = hit2 ? hw2 : lw2;
	assign tr2      = t2r[t2];
	assign ev_dirty = !hit2 && tv[lw2] && td[lw2];

	always_comb begin
		for (int w = 0; w < L2_WAYS; w++) begin
			ta_n[w] = ta[w];
			if (L2_RW'(w) == t2) begin
				t2rn[w] = '0;
			end else if (use2[w] && (t2r[w] < tr2)) begin
				t2rn[w] = L2_RW'(t2r[w] + 1'b1);
			end else begin
				t2rn[w] = t2r[w];
			end
		end
		tv_n = tv;
		td_n = td;
		if (hit2) begin
			td_n[hw2] = td[hw2] | op_wr;
		end else begin
			ta_n[lw2] = tag2;
			tv_n[lw2] = 1'b1;
			td_n[lw2] = op_wr;
		end
		for (int w = 0; w < L2_WAYS; w++) begin
			l2_wrow[w*L2_EW +: L2_EW] = {t2rn[w], td_n[w], tv_n[w], ta_n[w]};
		end
	end

	// per-item results
	logic       r_hit_q, r_swp_q, r_vhit_q, r_wb_q, r_rdi_q, r_wri_q;
	logic       r_rdm_q, r_wrm_q, need_r_q;
	logic [1:0] r_wbs_q;

	always_ff @(posedge clk) begin
		if (cmd.l1_upd) begin
			r_hit_q    <= hit;
			r_swp_q    <= swp;
			r_vhit_q   <= vhit;
			r_wb_q     <= wb;
			r_rdi_q    <= need_r;
			r_wri_q    <= need_w;
			r_rdm_q    <= 1'b0;
			r_wrm_q    <= 1'b0;
			r_wbs_q    <= 2'd0;
			need_r_q   <= need_r;
			l2w_addr_q <= swp ? vaddr_q[kl] : l1a[lw];
		end
		if (cmd.l2w_upd) begin
			r_wrm_q <= !hit2;
			r_wbs_q <= r_wbs_q + 2'(ev_dirty);
		end
		if (cmd.l2r_upd) begin
			r_rdm_q <= !hit2;
			r_wbs_q <= r_wbs_q + 2'(ev_dirty);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			l1_hit          <= r_hit_q;
			swap_request    <= r_swp_q;
			victim_hit      <= r_vhit_q;
			l1_writeback    <= r_wb_q;
			l2_read_issued  <= r_rdi_q;
			l2_write_issued <= r_wri_q;
			l2_read_miss    <= r_rdm_q;
			l2_write_miss   <= r_wrm_q;
			l2_writebacks   <= r_wbs_q;
		end
	end

	assign sts.clear_last = clear_last;
	assign sts.l1_need_w  = need_w;
	assign sts.l1_need_r  = need_r;
	assign sts.l2r_pend   = need_r_q;

endmodule
`default_nettype wire

// ----- design/l1_victim_l2_cache_tag_model.sv -----
// Top level of the L1 / victim / L2 cache tag model.
//
//  channel | signals                          | transfer
//  --------+----------------------------------+-------------------------
//  in      | in_valid in_ready kind block_addr | valid & ready
//  out     | out_valid out_ready result flags | valid & ready
//  cfg     | cfg_we cfg_index cfg_data        | cfg_we, no wait
//
// One item at a time: an L1 read and update step, then, if needed, an L2 write access
// and an L2 read access, each made of a read step and an update step on the L2 tag
// RAM, whose read is registered.
// After reset a clearing pass writes all 2**L2_SET_BITS L2 rows before the first item.
// A finished result sits in the output register; the next item is taken meanwhile.
`default_nettype none
module l1_victim_l2_cache_tag_model #(
	parameter int L1_SET_BITS  = 8,
	parameter int L1_WAYS      = 4,
	parameter int VICTIM_DEPTH = 8,
	parameter int L2_SET_BITS  = 10,
	parameter int L2_WAYS      = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [l1vl2_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [l1vl2_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             kind,
	input  logic [31:0]                      block_addr,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             l1_hit,
	output logic                             swap_request,
	output logic                             victim_hit,
	output logic                             l1_writeback,
	output logic                             l2_read_issued,
	output logic                             l2_write_issued,
	output logic                             l2_read_miss,
	output logic                             l2_write_miss,
	output logic [1:0]                       l2_writebacks
);
	import l1vl2_pkg::*;
	`include "assert_macros.svh"

	cmd_t cmd;
	sts_t sts;

	l1vl2_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	l1vl2_dp #(
		.L1_SET_BITS  (L1_SET_BITS),
		.L1_WAYS      (L1_WAYS),
		.VICTIM_DEPTH (VICTIM_DEPTH),
		.L2_SET_BITS  (L2_SET_BITS),
		.L2_WAYS      (L2_WAYS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.sts             (sts),
		.kind            (kind),
		.block_addr      (block_addr),
		.l1_hit          (l1_hit),
		.swap_request    (swap_request),
		.victim_hit      (victim_hit),
		.l1_writeback    (l1_writeback),
		.l2_read_issued  (l2_read_issued),
		.l2_write_issued (l2_write_issued),
		.l2_read_miss    (l2_read_miss),
		.l2_write_miss   (l2_write_miss),
		.l2_writebacks   (l2_writebacks)
	);

	`CHK_NEXT(a_one_item, in_valid && in_ready, !in_ready)
	`CHK_ALWAYS(a_hit_quiet, !out_valid || !l1_hit || (!swap_request && !l2_read_issued && !l1_writeback))
	`CHK_ALWAYS(a_vhit_no_l2, !out_valid || !victim_hit || (swap_request && !l2_read_issued && !l2_write_issued))
	`CHK_ALWAYS(a_miss_issued, !out_valid || ((!l2_read_miss || l2_read_issued) && (!l2_write_miss || l2_write_issued)))

endmodule
`default_nettype wire
